@@ rtl/core/isssd_pkg.sv @@
// Shared types, codes and helper functions for the inverter safe-state decider.
// Used by every module under rtl/core; depends on nothing else.
package isssd_pkg;

  localparam logic [2:0] ACT_RAMP_KEEP_CC     = 3'd1;
  localparam logic [2:0] ACT_RAMP_THEN_SPO    = 3'd2;
  localparam logic [2:0] ACT_ZERO_CURRENT     = 3'd3;
  localparam logic [2:0] ACT_SPO              = 3'd4;
  localparam logic [2:0] ACT_LS_ASC           = 3'd5;
  localparam logic [2:0] ACT_SPO_THEN_PWM_ASC = 3'd6;

  localparam logic [3:0] ROW_CMD_LOST     = 4'd0;
  localparam logic [3:0] ROW_BATTERY_LOST = 4'd1;
  localparam logic [3:0] ROW_BMS_ZERO     = 4'd2;
  localparam logic [3:0] ROW_RESOLVER     = 4'd3;
  localparam logic [3:0] ROW_HS           = 4'd4;
  localparam logic [3:0] ROW_LS           = 4'd5;
  localparam logic [3:0] ROW_V5GD         = 4'd6;
  localparam logic [3:0] ROW_OV           = 4'd7;
  localparam logic [3:0] ROW_OC           = 4'd8;

  localparam logic [2:0] REG_CROSSOVER_SPEED    = 3'd0;
  localparam logic [2:0] REG_TRIP_VOLTAGE       = 3'd1;
  localparam logic [2:0] REG_CAP_RATED_VOLTAGE  = 3'd2;
  localparam logic [2:0] REG_EMF_FLUX_COEFF     = 3'd3;
  localparam logic [2:0] REG_EMF_SALIENCY_COEFF = 3'd4;
  localparam logic [2:0] REG_ENERGY_D_COEFF     = 3'd5;
  localparam logic [2:0] REG_ENERGY_Q_COEFF     = 3'd6;
  localparam logic [2:0] REG_BATTERY_SINK       = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic       high;
    logic       forced;
    logic       b_row;
    logic       battery;
  } dec_t;

  typedef struct packed {
    dec_t        dec;
    logic [15:0] rpm;
    logic [30:0] id2;
    logic [30:0] iq2;
  } mag_sb_t;

  typedef struct packed {
    dec_t        dec;
    logic        e_sat;
    logic        big;
    logic [15:0] e;
  } pk_sb_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } sq_t;

  function automatic logic [15:0] mag16(input logic [15:0] x);
    return x[15] ? 16'(~x + 16'd1) : x;
  endfunction

  function automatic sq_t sq_step(input sq_t a, input logic [1:0] pair);
    logic [19:0] r;
    logic [19:0] t;
    sq_t         o;
    r = {a.rem, pair};
    t = {2'b00, a.root, 2'b01};
    if (r >= t) begin
      o.rem  = 18'(r - t);
      o.root = {a.root[14:0], 1'b1};
    end else begin
      o.rem  = r[17:0];
      o.root = {a.root[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [2:0] matrix_cell(input logic [3:0] row, input logic high,
                                             input logic battery);
    logic [2:0] act;
    case (row)
      ROW_CMD_LOST:     act = high ? (battery ? ACT_RAMP_KEEP_CC : ACT_LS_ASC)
                                   : ACT_RAMP_THEN_SPO;
      ROW_BATTERY_LOST: act = high ? ACT_LS_ASC : ACT_ZERO_CURRENT;
      ROW_BMS_ZERO:     act = high ? ACT_RAMP_KEEP_CC : ACT_RAMP_THEN_SPO;
      ROW_RESOLVER,
      ROW_OC:           act = high ? ACT_LS_ASC : ACT_SPO;
      ROW_HS:           act = high ? ACT_SPO_THEN_PWM_ASC : ACT_SPO;
      ROW_OV:           act = ACT_LS_ASC;
      default:          act = ACT_SPO;
    endcase
    return act;
  endfunction

endpackage

@@ rtl/core/isssd_sqrt.sv @@
// Pipelined integer square root of a 32-bit word, four result bits per stage.
// Carries a sideband word alongside; depends on isssd_pkg.
module isssd_sqrt import isssd_pkg::*; #(
  parameter type sb_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  sb_t         in_sb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_root,
  output sb_t         out_sb
);

  localparam int Stages = 4;
  localparam int Steps  = 4;

  logic        v       [Stages];
  sq_t         sq      [Stages];
  logic [31:0] val     [Stages];
  sb_t         sb      [Stages];
  logic        en      [Stages+1];
  logic        src_v   [Stages];
  sq_t         src_sq  [Stages];
  logic [31:0] src_val [Stages];
  sb_t         src_sb  [Stages];
  sq_t         nxt     [Stages];

  assign en[Stages] = out_ready;
  assign in_ready   = en[0];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src_v[s]   = in_valid;
      assign src_sq[s]  = '0;
      assign src_val[s] = in_value;
      assign src_sb[s]  = in_sb;
    end else begin : g_next
      assign src_v[s]   = v[s-1];
      assign src_sq[s]  = sq[s-1];
      assign src_val[s] = val[s-1];
      assign src_sb[s]  = sb[s-1];
    end

    assign en[s] = !v[s] || en[s+1];

    always_comb begin : c_steps
      sq_t x;
      x = src_sq[s];
      for (int k = 0; k < Steps; k++) begin
        x = sq_step(x, src_val[s][2*(15-(Steps*s+k)) +: 2]);
      end
      nxt[s] = x;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= src_v[s];
      end
      if (en[s]) begin
        sq[s]  <= nxt[s];
        val[s] <= src_val[s];
        sb[s]  <= src_sb[s];
      end
    end
  end

  assign out_valid = v[Stages-1];
  assign out_root  = sq[Stages-1].root;
  assign out_sb    = sb[Stages-1];

endmodule

@@ rtl/core/isssd_front.sv @@
// Input stage: speed class, matrix action, current magnitudes and their squares.
// Depends on isssd_pkg; feeds the current-magnitude square root.
module isssd_front import isssd_pkg::*; #(
  parameter int MAX_SPEED_RPM = 20000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         fault_row,
  input  logic               speed_valid,
  input  logic signed [15:0] speed,
  input  logic               battery_connected,
  input  logic signed [15:0] current_d,
  input  logic signed [15:0] current_q,
  input  logic [14:0]        crossover_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_value,
  output mag_sb_t            out_sb
);

  logic        av;
  dec_t        adec;
  logic [15:0] arpm;
  logic [15:0] aidm;
  logic [15:0] aiqm;
  logic        bv;
  mag_sb_t     bsb;
  logic [31:0] bsum;

  logic        en_a;
  logic        en_b;
  logic [15:0] spd_mag;
  logic        high;
  dec_t        dec_next;
  logic [31:0] id2_full;
  logic [31:0] iq2_full;

  assign en_b     = !bv || out_ready;
  assign en_a     = !av || en_b;
  assign in_ready = en_a;

  always_comb begin
    spd_mag          = mag16(speed);
    high             = !speed_valid || (spd_mag >= {1'b0, crossover_speed});
    dec_next.action  = matrix_cell(fault_row, high, battery_connected);
    dec_next.high    = high;
    dec_next.forced  = (fault_row == ROW_LS) || (fault_row == ROW_V5GD) ||
                       (fault_row == ROW_HS);
    dec_next.b_row   = (fault_row != ROW_BATTERY_LOST) && (fault_row != ROW_OV);
    dec_next.battery = battery_connected;
    id2_full         = aidm * aidm;
    iq2_full         = aiqm * aiqm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      bv <= 1'b0;
    end else begin
      if (en_a) av <= in_valid;
      if (en_b) bv <= av;
    end
    if (en_a) begin
      adec <= dec_next;
      arpm <= speed_valid ? spd_mag : 16'(MAX_SPEED_RPM);
      aidm <= mag16(current_d);
      aiqm <= mag16(current_q);
    end
    if (en_b) begin
      bsb.dec <= adec;
      bsb.rpm <= arpm;
      bsb.id2 <= id2_full[30:0];
      bsb.iq2 <= iq2_full[30:0];
      bsum    <= id2_full + iq2_full;
    end
  end

  assign out_valid = bv;
  assign out_value = bsum;
  assign out_sb    = bsb;

endmodule

@@ rtl/core/isssd_emf.sv @@
// Back-EMF and energy term: E, its trip check and the radicand for the peak.
// Depends on isssd_pkg; sits between the two square-root pipelines.
module isssd_emf import isssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_root,
  input  mag_sb_t     in_sb,
  input  logic [15:0] trip_voltage,
  input  logic [31:0] emf_flux_coeff,
  input  logic [31:0] emf_saliency_coeff,
  input  logic [31:0] energy_d_coeff,
  input  logic [31:0] energy_q_coeff,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output pk_sb_t      out_sb
);

  logic        v1, v2, v3, v4, v5;
  dec_t        dec1, dec2, dec3, dec4;
  logic [15:0] rpm1, rpm2;
  logic [47:0] salimag1;
  logic [62:0] pd1, pq1;
  logic [48:0] per2;
  logic [47:0] w2, w3, w4;
  logic [47:0] plo3;
  logic [32:0] phi3;
  logic [15:0] e4;
  logic        esat4;
  pk_sb_t      sb5;
  logic [31:0] val5;

  logic        en1, en2, en3, en4, en5;
  logic [63:0] wsum;
  logic [64:0] prod;
  logic [47:0] e48;
  logic [15:0] diff;
  logic [31:0] d2;
  logic [47:0] rad;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    wsum = 64'(pd1) + 64'(pq1);
    prod = {phi3, 32'b0} + 65'(plo3);
    e48  = prod[63:16];
    diff = trip_voltage - e4;
    d2   = diff * diff;
    rad  = {16'b0, d2} + w4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
    if (en1) begin
      dec1     <= in_sb.dec;
      rpm1     <= in_sb.rpm;
      salimag1 <= emf_saliency_coeff * in_root;
      pd1      <= energy_d_coeff * in_sb.id2;
      pq1      <= energy_q_coeff * in_sb.iq2;
    end
    if (en2) begin
      dec2 <= dec1;
      rpm2 <= rpm1;
      per2 <= 49'({emf_flux_coeff, 4'b0}) + 49'(salimag1);
      w2   <= wsum[63:16];
    end
    if (en3) begin
      dec3 <= dec2;
      w3   <= w2;
      plo3 <= rpm2 * per2[31:0];
      phi3 <= rpm2 * per2[48:32];
    end
    if (en4) begin
      dec4  <= dec3;
      w4    <= w3;
      e4    <= e48[15:0];
      esat4 <= e48 >= {32'b0, trip_voltage};
    end
    if (en5) begin
      sb5.dec   <= dec4;
      sb5.e_sat <= esat4;
      sb5.big   <= |rad[47:32];
      sb5.e     <= e4;
      val5      <= rad[31:0];
    end
  end

  assign out_valid = v5;
  assign out_value = val5;
  assign out_sb    = sb5;

endmodule

@@ rtl/core/isssd_decide.sv @@
// Final stage: peak voltage, release rules, fallback and the output register.
// Depends on isssd_pkg; drives the result ports of the top level.
module isssd_decide import isssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_root,
  input  pk_sb_t      in_sb,
  input  logic [15:0] capacitor_rated_voltage,
  input  logic        battery_sink_released,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic        is_high_speed,
  output logic        asc_allowed,
  output logic        spo_is_forced,
  output logic [15:0] peak_voltage,
  output logic        rule_a_ok,
  output logic        rule_b_ok,
  output logic        spo_is_wanted,
  output logic        spo_was_refused,
  output logic        energy_fault,
  output logic        keep_high_voltage
);

  logic        en;
  logic [16:0] pk17;
  logic [15:0] pk;
  logic        rule_a;
  logic        rule_b;
  logic        asc_ok;
  logic        wanted;
  logic        refused;
  logic        efault;
  logic [2:0]  act;
  logic        held;

  assign en       = !out_valid || !out_stall;
  assign in_ready = en;

  always_comb begin
    pk17    = {1'b0, in_sb.e} + {1'b0, in_root};
    pk      = (in_sb.e_sat || in_sb.big || pk17[16]) ? 16'hFFFF : pk17[15:0];
    rule_a  = pk < capacitor_rated_voltage;
    rule_b  = battery_sink_released && in_sb.dec.battery && in_sb.dec.b_row;
    asc_ok  = !in_sb.dec.forced;
    act     = in_sb.dec.action;
    wanted  = (act == ACT_SPO) || (act == ACT_SPO_THEN_PWM_ASC);
    refused = wanted && !rule_a && !rule_b;
    efault  = 1'b0;
    if (refused) begin
      if ((act == ACT_SPO) && asc_ok) begin
        act = ACT_LS_ASC;
      end else begin
        efault = 1'b1;
      end
    end
    if ((act == ACT_LS_ASC) && !asc_ok) begin
      act = ACT_SPO;
    end
    held = (act == ACT_SPO) || (act == ACT_SPO_THEN_PWM_ASC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      action            <= act;
      is_high_speed     <= in_sb.dec.high;
      asc_allowed       <= asc_ok;
      spo_is_forced     <= in_sb.dec.forced;
      peak_voltage      <= pk;
      rule_a_ok         <= rule_a;
      rule_b_ok         <= rule_b;
      spo_is_wanted     <= wanted;
      spo_was_refused   <= refused;
      energy_fault      <= efault;
      keep_high_voltage <= held && !rule_a && in_sb.dec.battery && in_sb.dec.b_row;
    end
  end

endmodule

@@ rtl/core/inverter_safe_state_decider.sv @@
// Inverter safe-state decider: one result word per fault event, fully pipelined.
// A word is taken every cycle while in_stall is low; its result passes through two front
// stages, two four-stage square-root pipelines, five EMF stages and the output register,
// and a stalled output backs up only through full stages.
// Depends on isssd_pkg, isssd_front, isssd_sqrt, isssd_emf and isssd_decide.
module inverter_safe_state_decider import isssd_pkg::*; #(
  parameter int MAX_SPEED_RPM = 20000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         fault_row,
  input  logic               speed_valid,
  input  logic signed [15:0] speed,
  input  logic               battery_connected,
  input  logic signed [15:0] current_d,
  input  logic signed [15:0] current_q,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         action,
  output logic               is_high_speed,
  output logic               asc_allowed,
  output logic               spo_is_forced,
  output logic [15:0]        peak_voltage,
  output logic               rule_a_ok,
  output logic               rule_b_ok,
  output logic               spo_is_wanted,
  output logic               spo_was_refused,
  output logic               energy_fault,
  output logic               keep_high_voltage,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [14:0] crossover_speed;
  logic [15:0] trip_voltage;
  logic [15:0] capacitor_rated_voltage;
  logic [31:0] emf_flux_coeff;
  logic [31:0] emf_saliency_coeff;
  logic [31:0] energy_d_coeff;
  logic [31:0] energy_q_coeff;
  logic        battery_sink_released;

  logic        front_ready;
  logic        f_valid, f_ready;
  logic [31:0] f_value;
  mag_sb_t     f_sb;
  logic        s1_valid, s1_ready;
  logic [15:0] s1_root;
  mag_sb_t     s1_sb;
  logic        e_valid, e_ready;
  logic [31:0] e_value;
  pk_sb_t      e_sb;
  logic        s2_valid, s2_ready;
  logic [15:0] s2_root;
  pk_sb_t      s2_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossover_speed         <= '0;
      trip_voltage            <= 16'hFFFF;
      capacitor_rated_voltage <= '0;
      emf_flux_coeff          <= '0;
      emf_saliency_coeff      <= '0;
      energy_d_coeff          <= '0;
      energy_q_coeff          <= '0;
      battery_sink_released   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CROSSOVER_SPEED:    crossover_speed         <= cfg_data[14:0];
        REG_TRIP_VOLTAGE:       trip_voltage            <= cfg_data[15:0];
        REG_CAP_RATED_VOLTAGE:  capacitor_rated_voltage <= cfg_data[15:0];
        REG_EMF_FLUX_COEFF:     emf_flux_coeff          <= cfg_data;
        REG_EMF_SALIENCY_COEFF: emf_saliency_coeff      <= cfg_data;
        REG_ENERGY_D_COEFF:     energy_d_coeff          <= cfg_data;
        REG_ENERGY_Q_COEFF:     energy_q_coeff          <= cfg_data;
        REG_BATTERY_SINK:       battery_sink_released   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = !front_ready;

  isssd_front #(.MAX_SPEED_RPM(MAX_SPEED_RPM)) u_front (
    .clk, .rst,
    .in_valid, .in_ready(front_ready),
    .fault_row, .speed_valid, .speed, .battery_connected, .current_d, .current_q,
    .crossover_speed,
    .out_valid(f_valid), .out_ready(f_ready), .out_value(f_value), .out_sb(f_sb)
  );

  isssd_sqrt #(.sb_t(mag_sb_t)) u_imag (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_value(f_value), .in_sb(f_sb),
    .out_valid(s1_valid), .out_ready(s1_ready), .out_root(s1_root), .out_sb(s1_sb)
  );

  isssd_emf u_emf (
    .clk, .rst,
    .in_valid(s1_valid), .in_ready(s1_ready), .in_root(s1_root), .in_sb(s1_sb),
    .trip_voltage, .emf_flux_coeff, .emf_saliency_coeff, .energy_d_coeff,
    .energy_q_coeff,
    .out_valid(e_valid), .out_ready(e_ready), .out_value(e_value), .out_sb(e_sb)
  );

  isssd_sqrt #(.sb_t(pk_sb_t)) u_peak (
    .clk, .rst,
    .in_valid(e_valid), .in_ready(e_ready), .in_value(e_value), .in_sb(e_sb),
    .out_valid(s2_valid), .out_ready(s2_ready), .out_root(s2_root), .out_sb(s2_sb)
  );

  isssd_decide u_decide (
    .clk, .rst,
    .in_valid(s2_valid), .in_ready(s2_ready), .in_root(s2_root), .in_sb(s2_sb),
    .capacitor_rated_voltage, .battery_sink_released,
    .out_valid, .out_stall,
    .action, .is_high_speed, .asc_allowed, .spo_is_forced, .peak_voltage,
    .rule_a_ok, .rule_b_ok, .spo_is_wanted, .spo_was_refused, .energy_fault,
    .keep_high_voltage
  );

endmodule
